// ===== design/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared constants, types and coefficient rom
// sizes of the folded symmetric fir decimator, the controller/datapath
// command and status bundles, and the hamming-windowed sinc taps built at
// elaboration with integer arithmetic
// ----------------------------------------------------------------------------
package sfd_pkg;

   // build-time configuration
   localparam int TAPS         = 101;
   localparam int DECIMATION   = 4;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 18;

   // derived sizes
   localparam int HALF     = (TAPS - 1) / 2;
   localparam int ADDR_W   = $clog2(TAPS);
   localparam int IDX_W    = $clog2(HALF + 1);
   localparam int RING_OFF = TAPS - 2 * HALF;
   localparam int PAIR_W   = SAMPLE_WIDTH + 1;
   localparam int PROD_W   = PAIR_W + COEF_WIDTH;
   localparam int ACC_W    = PROD_W + IDX_W + 1;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(HALF);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPS - 1);

   // output rounding and saturation limits in accumulator width
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_WIDTH - 2);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

   // fixed-point constants for the rom build
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam longint      ONE_Q30 = 64'sd1073741824;
   localparam int          ROM_SH  = 61 - COEF_WIDTH;

   typedef logic [HALF:0][COEF_WIDTH-1:0] coef_rom_type;

   typedef struct packed {
      logic             store;
      logic             acc_clear;
      logic             issue;
      logic             center;
      logic [IDX_W-1:0] idx;
      logic             finish;
   } dp_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

   // restoring long division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[62:0], num[k]};
         if (r >= den) begin
            r    = r - den;
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // sin(pi*a/b) in q30, taylor series after first-quadrant reduction
   function automatic logic signed [63:0] sin_pi(input logic [63:0] a_arg,
                                                 input logic [63:0] b);
      logic [63:0] a;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic        neg;
      logic        sub;
      a   = a_arg - udiv64(a_arg, 64'd2 * b) * (64'd2 * b);
      neg = 1'b0;
      if (a >= b) begin
         neg = 1'b1;
         a   = a - b;
      end
      if (64'd2 * a > b) begin
         a = b - a;
      end
      x    = udiv64(PI_Q30 * a, b);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      sub  = 1'b1;
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         term = udiv64(term, 64'(2 * k) * 64'(2 * k + 1));
         if (sub) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         sub = !sub;
      end
      if (sum > 64'(ONE_Q30)) begin
         sum = 64'(ONE_Q30);
      end
      return neg ? -signed'(sum) : signed'(sum);
   endfunction

   function automatic coef_rom_type build_rom();
      coef_rom_type       rom;
      logic [63:0]        m;
      logic [63:0]        den;
      logic [63:0]        mag;
      logic [63:0]        hd;
      logic [63:0]        w;
      logic [63:0]        r;
      logic signed [63:0] s;
      logic signed [63:0] c;
      logic signed [63:0] wt;
      logic signed [63:0] v;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      for (int i = 0; i < HALF; i++) begin
         m   = 64'(HALF - i);
         s   = sin_pi(64'd9 * m, 64'(10 * DECIMATION));
         den = PI_Q30 * m;
         mag = (s < 0) ? 64'(-s) : 64'(s);
         hd  = udiv64(mag << 30, den);
         c   = sin_pi(64'(2 * i + HALF), 64'(2 * HALF));
         wt  = 64'sd54 * ONE_Q30 - 64'sd46 * c;
         w   = udiv64(64'(wt), 64'd100);
         r   = (hd * w + (64'd1 << (ROM_SH - 1))) >> ROM_SH;
         v   = (s < 0) ? -signed'(r) : signed'(r);
         if (v > hi) begin
            v = hi;
         end else if (v < lo) begin
            v = lo;
         end
         rom[i] = v[COEF_WIDTH-1:0];
      end
      v = signed'(udiv64((64'd9 << COEF_WIDTH) + 64'(10 * DECIMATION),
                         64'(20 * DECIMATION)));
      if (v > hi) begin
         v = hi;
      end else if (v < lo) begin
         v = lo;
      end
      rom[HALF] = v[COEF_WIDTH-1:0];
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = build_rom();

endpackage

// ===== design/sfd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ram: generic one-write two-read ram
// single write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 101
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== design/sfd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ctrl: decimator sequencer
// accepts transactions, steps the folded tap index and hands the result to
// the output register once the mac pipeline has drained
// ----------------------------------------------------------------------------
module sfd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_emit_output,
   output logic                  req_stall,
   output sfd_pkg::dp_cmd_type   cmd,
   input  sfd_pkg::dp_status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   logic [sfd_pkg::IDX_W-1:0] idx_ff;
   logic [sfd_pkg::IDX_W-1:0] idx_in;
   logic                     accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.store     = 1'b1;
               cmd.acc_clear = 1'b1;
               if (req_emit_output) begin
                  idx_in   = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue  = 1'b1;
            cmd.center = (idx_ff == sfd_pkg::LAST_IDX);
            if (idx_ff == sfd_pkg::LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== design/sfd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_datapath: delay ring, folded mac pipeline and output register
// ring read at two taps a cycle, pair add, one shared multiplier,
// accumulator, then rounding, saturation and the result register
// ----------------------------------------------------------------------------
module sfd_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sfd_pkg::dp_cmd_type                     cmd,
   output sfd_pkg::dp_status_type                  status,
   input  logic signed [sfd_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [sfd_pkg::SAMPLE_WIDTH-1:0] rsp_filtered_out
);

   localparam int SW = sfd_pkg::SAMPLE_WIDTH;
   localparam int AW = sfd_pkg::ADDR_W;

   // ring bookkeeping
   logic [AW-1:0]           wr_pos_ff, wr_pos_in;
   logic [AW-1:0]           addr_a_ff, addr_a_in;
   logic [AW-1:0]           addr_b_ff, addr_b_in;
   logic [sfd_pkg::TAPS-1:0] ring_valid_ff, ring_valid_in;
   logic [AW:0]             start_b;
   logic [SW-1:0]           rd_a, rd_b;

   // mac pipeline
   logic                                      v1_ff, v2_ff, v3_ff;
   logic                                      ok_a_ff, ok_b_ff, center1_ff;
   logic signed [sfd_pkg::COEF_WIDTH-1:0]     coef1_ff, coef2_ff;
   logic signed [sfd_pkg::PAIR_W-1:0]         pair_ff, pair_in;
   logic signed [sfd_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic signed [sfd_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic signed [SW-1:0]                      opnd_a, opnd_b;

   // output stage
   logic signed [sfd_pkg::ACC_W-1:0] rounded, shifted;
   logic signed [SW-1:0]             sat_value;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]             rsp_data_ff;

   sfd_ram #(
      .WIDTH (SW),
      .DEPTH (sfd_pkg::TAPS)
   ) u_ring (
      .clock     (clock),
      .wr_en     (cmd.store),
      .wr_addr   (wr_pos_ff),
      .wr_data   (req_sample_in),
      .rd_addr_a (addr_a_ff),
      .rd_addr_b (addr_b_ff),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // write pointer and tap address walkers
   always_comb begin
      start_b = {1'b0, wr_pos_ff} + (AW + 1)'(sfd_pkg::RING_OFF);
      if (start_b >= (AW + 1)'(sfd_pkg::TAPS)) begin
         start_b = start_b - (AW + 1)'(sfd_pkg::TAPS);
      end
      wr_pos_in     = wr_pos_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      ring_valid_in = ring_valid_ff;
      if (cmd.store) begin
         wr_pos_in = (wr_pos_ff == sfd_pkg::LAST_ADDR) ? '0 : wr_pos_ff + 1'b1;
         addr_a_in = wr_pos_ff;
         addr_b_in = start_b[AW-1:0];
         ring_valid_in[wr_pos_ff] = 1'b1;
      end else if (cmd.issue) begin
         addr_a_in = (addr_a_ff == '0) ? sfd_pkg::LAST_ADDR : addr_a_ff - 1'b1;
         addr_b_in = (addr_b_ff == sfd_pkg::LAST_ADDR) ? '0 : addr_b_ff + 1'b1;
      end
   end

   // pair, product, accumulate
   always_comb begin
      opnd_a  = ok_a_ff ? signed'(rd_a) : '0;
      opnd_b  = (ok_b_ff && !center1_ff) ? signed'(rd_b) : '0;
      pair_in = {opnd_a[SW-1], opnd_a} + {opnd_b[SW-1], opnd_b};
      prod_in = pair_ff * coef2_ff;
      acc_in  = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_ff + {{(sfd_pkg::ACC_W - sfd_pkg::PROD_W){prod_ff[sfd_pkg::PROD_W-1]}},
                            prod_ff};
      end
   end

   // round half up, then saturate
   always_comb begin
      rounded = acc_ff + sfd_pkg::RND_HALF;
      shifted = rounded >>> (sfd_pkg::COEF_WIDTH - 1);
      if (shifted > sfd_pkg::SAT_HI) begin
         sat_value = sfd_pkg::SAT_HI[SW-1:0];
      end else if (shifted < sfd_pkg::SAT_LO) begin
         sat_value = sfd_pkg::SAT_LO[SW-1:0];
      end else begin
         sat_value = shifted[SW-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff     <= '0;
         ring_valid_ff <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_pos_ff     <= wr_pos_in;
         ring_valid_ff <= ring_valid_in;
         v1_ff         <= cmd.issue;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_a_ff  <= addr_a_in;
      addr_b_ff  <= addr_b_in;
      ok_a_ff    <= ring_valid_ff[addr_a_ff];
      ok_b_ff    <= ring_valid_ff[addr_b_ff];
      center1_ff <= cmd.center;
      coef1_ff   <= signed'(sfd_pkg::COEF_ROM[cmd.idx]);
      coef2_ff   <= coef1_ff;
      pair_ff    <= pair_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      if (cmd.finish) begin
         rsp_data_ff <= sat_value;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_data_ff;

endmodule

// ===== design/symmetric_fir_decimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir_decimator_top: folded linear-phase fir decimator
// stores each sample in a 101-entry delay ring and, on request, forms one
// hamming-windowed sinc output rounded and saturated to q1.15
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall | req_sample_in, req_emit_output
//   rsp     | out       | rsp_valid/rsp_stall | rsp_filtered_out
//
// a transaction without the emit flag only writes the sample and raises no stall,
// so the next transaction is taken in the following cycle
// an emitting transaction holds req_stall while the sequencer walks one folded
// tap pair per cycle through the single shared multiplier, drains the mac
// pipeline and loads the output register
// synchronous active-high reset clears the ring valid bits at once, so no
// clearing pass is needed and the ring reads as zero until written
// a result waiting in the output register does not block input; only the
// next emitting transaction waits for it to be taken before loading
//
module symmetric_fir_decimator_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // input transactions
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sfd_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                                    req_emit_output,
   // result transactions
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [sfd_pkg::SAMPLE_WIDTH-1:0] rsp_filtered_out
);

   // command and status between sequencer and datapath
   sfd_pkg::dp_cmd_type    cmd;
   sfd_pkg::dp_status_type status;

   // sequencer: accepts transactions and walks the 51 folded taps
   sfd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_emit_output (req_emit_output),
      .req_stall       (req_stall),
      .cmd             (cmd),
      .status          (status)
   );

   // ring memory, mac pipeline and output register
   sfd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered_out (rsp_filtered_out)
   );

   // a result only appears after the sequencer commits one
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result appeared without a finish command");

   // the output register is never overwritten while a result is still held
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("finish while output register blocked");

   // new transactions are only taken with an empty mac pipeline
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !status.pipe_busy)
      else $error("input taken while mac pipeline busy");

   // an emitting transaction starts the tap walk in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_emit_output) |=> (req_stall && cmd.issue))
      else $error("emitting transaction did not start the tap walk");

endmodule
